// ===== hw/rtl/wsd_pkg.sv =====
package wsd_pkg;

  // One payload word on its way from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } wsd_entry_t;

  // Queue status seen by the parser and the output stage.
  typedef struct packed {
    logic full;
    logic valid;
  } wsd_q_status_t;

endpackage

// ===== hw/rtl/wsd_parser.sv =====
module wsd_parser import wsd_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output wsd_entry_t entry_o
);

  localparam logic [2:0] PhHdr0 = 3'd0;
  localparam logic [2:0] PhHdr1 = 3'd1;
  localparam logic [2:0] PhExt  = 3'd2;
  localparam logic [2:0] PhKey  = 3'd3;
  localparam logic [2:0] PhData = 3'd4;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] ExtOne     = 4'd1;
  localparam logic [2:0] KeyBytes   = 3'd4;
  localparam logic [2:0] KeyOne     = 3'd1;
  localparam logic [LENGTH_WIDTH-1:0] RemZero = '0;
  localparam logic [LENGTH_WIDTH-1:0] RemOne  = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

  logic [2:0]              phase_q, phase_d;
  logic                    fin_q, fin_d;
  logic [3:0]              opcode_q, opcode_d;
  logic                    mask_q, mask_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
  logic [3:0]              ext_q, ext_d;
  logic [31:0]             key_q, key_d;
  logic [2:0]              key_left_q, key_left_d;
  logic [1:0]              pos_q, pos_d;

  logic                    accept;
  logic [6:0]              len7;
  logic [LENGTH_WIDTH-1:0] rem_shift;
  logic [7:0]              key_byte;

  // Header bytes never wait; only payload words need room in the queue.
  assign in_ready_o = !((phase_q == PhData) && q_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign len7       = in_byte_i[6:0];
  assign rem_shift  = {rem_q[LENGTH_WIDTH-9:0], in_byte_i};

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign entry_o.data   = in_byte_i;
  assign entry_o.key    = key_byte;
  assign entry_o.opcode = opcode_q;
  assign entry_o.fin    = fin_q;
  assign entry_o.last   = (rem_q == RemOne);

  always_comb begin
    phase_d    = phase_q;
    fin_d      = fin_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    rem_d      = rem_q;
    ext_d      = ext_q;
    key_d      = key_q;
    key_left_d = key_left_q;
    pos_d      = pos_q;
    push_o     = 1'b0;
    if (accept) begin
      case (phase_q)
        PhHdr1: begin
          mask_d = in_byte_i[7];
          key_d  = '0;
          pos_d  = '0;
          rem_d  = RemZero;
          if (len7 == Len16Code) begin
            ext_d   = ExtBytes16;
            phase_d = PhExt;
          end else if (len7 == Len64Code) begin
            ext_d   = ExtBytes64;
            phase_d = PhExt;
          end else begin
            rem_d = {{(LENGTH_WIDTH-7){1'b0}}, len7};
            if (in_byte_i[7]) begin
              key_left_d = KeyBytes;
              phase_d    = PhKey;
            end else if (len7 == 7'd0) begin
              phase_d = PhHdr0;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhExt: begin
          rem_d = rem_shift;
          ext_d = ext_q - 4'd1;
          if (ext_q == ExtOne) begin
            if (mask_q) begin
              key_left_d = KeyBytes;
              phase_d    = PhKey;
            end else if (rem_shift == RemZero) begin
              phase_d = PhHdr0;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhKey: begin
          key_d      = {key_q[23:0], in_byte_i};
          key_left_d = key_left_q - 3'd1;
          if (key_left_q == KeyOne) begin
            phase_d = (rem_q == RemZero) ? PhHdr0 : PhData;
          end
        end
        PhData: begin
          push_o = 1'b1;
          pos_d  = pos_q + 2'd1;
          rem_d  = rem_q - RemOne;
          if (rem_q == RemOne) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          fin_d    = in_byte_i[7];
          opcode_d = in_byte_i[3:0];
          phase_d  = PhHdr1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr0;
      fin_q      <= 1'b0;
      opcode_q   <= '0;
      mask_q     <= 1'b0;
      rem_q      <= '0;
      ext_q      <= '0;
      key_q      <= '0;
      key_left_q <= '0;
      pos_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      fin_q      <= fin_d;
      opcode_q   <= opcode_d;
      mask_q     <= mask_d;
      rem_q      <= rem_d;
      ext_q      <= ext_d;
      key_q      <= key_d;
      key_left_q <= key_left_d;
      pos_q      <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/wsd_fifo.sv =====
module wsd_fifo import wsd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_entry_t    entry_i,
  input  logic          pop_i,
  output wsd_q_status_t status_o,
  output wsd_entry_t    entry_o
);

  localparam logic [1:0] Depth = 2'd2;

  wsd_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign status_o.full  = (count_q == Depth);
  assign status_o.valid = (count_q != 2'd0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign entry_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/wsd_unmask.sv =====
module wsd_unmask import wsd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsd_q_status_t status_i,
  input  wsd_entry_t    entry_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_data_o,
  output logic [3:0]    out_opcode_o,
  output logic          out_fin_o,
  output logic          out_last_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic [3:0] opcode_q;
  logic       fin_q, last_q;

  // The output register refills in the same cycle that its word is taken.
  assign pop_o = status_i.valid && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q   <= entry_i.data ^ entry_i.key;
      opcode_q <= entry_i.opcode;
      fin_q    <= entry_i.fin;
      last_q   <= entry_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_data_o   = data_q;
  assign out_opcode_o = opcode_q;
  assign out_fin_o    = fin_q;
  assign out_last_o   = last_q;

endmodule

// ===== hw/rtl/websocket_frame_deframer_top.sv =====
// WebSocket receive deframer: takes the received stream one byte per word and
// emits each payload byte, unmasked, with its frame's opcode and FIN bit in
// tuser and tlast on the last payload byte of the frame. Header, extended
// length and mask key bytes produce no output, nor do zero-length frames.
// The block sustains one byte per clock except when it stalls: header bytes are
// always taken at once, while payload bytes wait only when the two-word queue
// in front of the output register is full, which happens only after the
// downstream side has held tready low. An accepted payload byte passes through
// the queue and then the output register. LENGTH_WIDTH sets how many low bits
// of the 64-bit extended length are kept (16 to 64).
module websocket_frame_deframer_top import wsd_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] payload_byte
  output logic [4:0] m_axis_tuser_o,  // [3:0] frame_opcode, [4] final_fragment
  output logic       m_axis_tlast_o
);

  logic          push;
  logic          pop;
  wsd_entry_t    push_entry;
  wsd_entry_t    head_entry;
  wsd_q_status_t q_status;
  logic [3:0]    out_opcode;
  logic          out_fin;

  wsd_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .q_full_i   (q_status.full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  wsd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .status_o (q_status),
    .entry_o  (head_entry)
  );

  wsd_unmask u_unmask (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .status_i     (q_status),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_opcode_o (out_opcode),
    .out_fin_o    (out_fin),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = {out_fin, out_opcode};

  // A payload word is never offered to a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("payload word pushed into a full queue");

  // The output stage only drains a queue that holds something.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_status.valid)
    else $error("queue popped while empty");

  // Input back-pressure comes only from a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_status.full)
    else $error("input stalled while the queue has room");

  // A full queue implies the output register is holding a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> m_axis_tvalid_o)
    else $error("queue full while the output register is empty");

endmodule

// ===== verif/websocket_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;
  import wsd_pkg::*;

  localparam int unsigned LEN_W = 64;
  localparam logic [63:0] LEN_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_W);
  localparam int unsigned RANDOM_BYTES = 1300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HEADER0,
    PH_HEADER1,
    PH_EXT_LEN,
    PH_MASK_KEY,
    PH_PAYLOAD
  } parse_phase_e;

  typedef enum int {
    ENC_SHORT,
    ENC_EXT16,
    ENC_EXT64
  } len_enc_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } payload_word_t;

  class deframe_checker;
    parse_phase_e  phase = PH_HEADER0;
    logic          fin = 1'b0;
    logic [3:0]    opcode = '0;
    logic          masked = 1'b0;
    logic [63:0]   remaining = '0;
    logic [3:0]    ext_left = '0;
    logic [31:0]   key = '0;
    logic [2:0]    key_left = '0;
    logic [1:0]    key_pos = '0;
    payload_word_t expected_payload[$];
    int unsigned   errors = 0;

    function void length_done();
      if (masked) begin
        key_left = 3'd4;
        phase = PH_MASK_KEY;
      end else if (remaining == 0) begin
        phase = PH_HEADER0;
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    // Advances the parser by one received byte and queues the payload word it yields.
    function void take_byte(logic [7:0] b);
      payload_word_t w;
      logic [31:0] shifted;
      case (phase)
        PH_HEADER1: begin
          masked = b[7];
          key = '0;
          key_pos = '0;
          remaining = '0;
          if (b[6:0] == LEN_EXT16) begin
            ext_left = 4'd2;
            phase = PH_EXT_LEN;
          end else if (b[6:0] == LEN_EXT64) begin
            ext_left = 4'd8;
            phase = PH_EXT_LEN;
          end else begin
            remaining = 64'(b[6:0]);
            length_done();
          end
        end
        PH_EXT_LEN: begin
          remaining = {remaining[55:0], b} & LEN_MASK;
          ext_left = ext_left - 4'd1;
          if (ext_left == 0) length_done();
        end
        PH_MASK_KEY: begin
          key = {key[23:0], b};
          key_left = key_left - 3'd1;
          if (key_left == 0) phase = (remaining == 0) ? PH_HEADER0 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          shifted = key >> (24 - 8 * key_pos);
          w.data = b ^ shifted[7:0];
          w.opcode = opcode;
          w.fin = fin;
          w.last = (remaining == 64'd1);
          expected_payload = {expected_payload, w};
          key_pos = key_pos + 2'd1;
          remaining = (remaining - 64'd1) & LEN_MASK;
          if (remaining == 0) phase = PH_HEADER0;
        end
        default: begin
          fin = b[7];
          opcode = b[3:0];
          phase = PH_HEADER1;
        end
      endcase
    endfunction

    function void check_payload(logic [7:0] data, logic [4:0] user, logic last);
      payload_word_t w;
      if (expected_payload.size() == 0) begin
        $error("unexpected payload word: data %02h user %02h last %0d", data, user, last);
        errors++;
        return;
      end
      w = expected_payload.pop_front();
      if (data !== w.data) begin
        $error("payload_byte: expected %02h, got %02h", w.data, data);
        errors++;
      end
      if (user[3:0] !== w.opcode) begin
        $error("frame_opcode: expected %0h, got %0h", w.opcode, user[3:0]);
        errors++;
      end
      if (user[4] !== w.fin) begin
        $error("final_fragment: expected %0d, got %0d", w.fin, user[4]);
        errors++;
      end
      if (last !== w.last) begin
        $error("frame_last: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_payload.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [4:0] m_axis_tuser;
  logic       m_axis_tlast;

  deframe_checker sb = new();
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  websocket_frame_deframer_top #(.LENGTH_WIDTH(LEN_W)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("websocket_frame_deframer_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_payload(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Downstream side: holds tready high until a word moves, then may stall.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // Sends one complete frame with random payload bytes.
  task automatic send_frame(input logic [7:0] hdr0, input int unsigned len,
                            input len_enc_e enc, input logic masked,
                            input logic [31:0] key);
    logic [63:0] len64;
    len64 = 64'(len);
    send_byte(hdr0);
    case (enc)
      ENC_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      ENC_EXT64: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len64[8*i +: 8]);
      end
      default: send_byte({masked, len64[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    len_enc_e enc;
    int unsigned wait_cycles;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Unmasked frame with all reserved bits set and payload extremes.
    send_byte(8'hF1);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    // Unmasked zero-length ping.
    send_byte(8'h89);
    send_byte(8'h00);
    // 16-bit extended length of one byte.
    send_byte(8'h8A);
    send_byte({1'b0, LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h7E);
    // Masked continuation fragment with a 64-bit length of two bytes.
    send_byte(8'h00);
    send_byte({1'b1, LEN_EXT64});
    repeat (7) send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);

    // Random frames; idling on each side switches on and off between frames.
    while (bytes_sent < RANDOM_BYTES) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) len = $urandom_range(0, 20);
      else if (pick < 85) len = $urandom_range(21, 125);
      else len = $urandom_range(126, 400);
      if (len > 125) enc = len_enc_e'($urandom_range(ENC_EXT16, ENC_EXT64));
      else if ($urandom_range(0, 7) == 0) enc = len_enc_e'($urandom_range(ENC_EXT16, ENC_EXT64));
      else enc = ENC_SHORT;
      send_frame(8'($urandom_range(0, 255)), len, enc, 1'($urandom_range(0, 1)),
                 $urandom());
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    wait_cycles = DRAIN_CYCLES;
    repeat (wait_cycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("websocket_frame_deframer_top_tb passed");
    end else begin
      $display("websocket_frame_deframer_top_tb failed");
    end
    $finish;
  end

endmodule
